FILE: hdl/wavelet_coeff_quantizer_assert.svh
// assertion macros for the coefficient quantizer
`ifndef WAVELET_COEFF_QUANTIZER_ASSERT_SVH
`define WAVELET_COEFF_QUANTIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define WCQ_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
`define WCQ_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define WCQ_ASSERT_IMPL(label, clk, rst_n, a, b, msg)
`define WCQ_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif

`endif

FILE: hdl/wcq_pkg.sv
package wcq_pkg;

  localparam int DATA_W     = 16;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DATA_W / DIV_BITS;

  localparam logic [0:0] REG_STEP = 1'b0;
  localparam logic [0:0] REG_BIAS = 1'b1;

  localparam logic MODE_QUANT   = 1'b0;
  localparam logic MODE_DEQUANT = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dvd;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] dsr;
  } div_t;

  typedef struct packed {
    logic              mode;
    logic              neg;
    logic [DATA_W-1:0] lmag;
    logic              lpos;
    logic [DATA_W-1:0] recon;
    logic              clip;
  } side_t;

  typedef struct packed {
    logic                mode;
    logic                neg;
    logic [DATA_W-1:0]   lmag;
    logic                lpos;
    logic [2*DATA_W-1:0] prod;
    div_t                div;
  } front_t;

endpackage

FILE: hdl/wcq_front.sv
module wcq_front (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 mode,
  input  logic signed [15:0]   coefficient,
  input  logic [15:0]          level_magnitude,
  input  logic                 level_positive,
  input  logic [15:0]          quant_step,
  input  logic [15:0]          quant_bias,
  output wcq_pkg::front_t      f_out
);
  import wcq_pkg::*;

  logic [15:0] step_eff;
  logic        neg;
  logic [16:0] mag;
  logic [16:0] up;
  logic [15:0] dividend;
  front_t      f_nxt;
  front_t      f_r;

  always_comb begin
    step_eff = (quant_step == 16'd0) ? 16'd1 : quant_step;
    neg      = coefficient[15];
    mag      = neg ? (17'h10000 - {1'b0, coefficient}) : {1'b0, coefficient};
    up       = mag + {2'b0, step_eff[15:1]};
    dividend = (up >= {1'b0, quant_bias}) ? 16'(up - {1'b0, quant_bias}) : 16'd0;

    f_nxt.mode    = mode;
    f_nxt.neg     = neg;
    f_nxt.lmag    = level_magnitude;
    f_nxt.lpos    = level_positive;
    f_nxt.prod    = level_magnitude * step_eff;
    f_nxt.div.rem = '0;
    f_nxt.div.dvd = dividend;
    f_nxt.div.quo = '0;
    f_nxt.div.dsr = step_eff;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_nxt;
    end
  end

  assign f_out = f_r;

endmodule

FILE: hdl/wcq_div_stage.sv
module wcq_div_stage (
  input  logic           clk,
  input  logic           en,
  input  wcq_pkg::div_t  d_in,
  input  wcq_pkg::side_t sd_in,
  output wcq_pkg::div_t  d_out,
  output wcq_pkg::side_t sd_out
);
  import wcq_pkg::*;

  div_t  d_nxt;
  div_t  d_r;
  side_t sd_r;

  // restoring division, DIV_BITS quotient bits per stage
  always_comb begin
    logic [DATA_W:0] trial;
    d_nxt = d_in;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial     = {d_nxt.rem, d_nxt.dvd[DATA_W-1]};
      d_nxt.dvd = {d_nxt.dvd[DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, d_nxt.dsr}) begin
        d_nxt.rem = DATA_W'(trial - {1'b0, d_nxt.dsr});
        d_nxt.quo = {d_nxt.quo[DATA_W-2:0], 1'b1};
      end else begin
        d_nxt.rem = trial[DATA_W-1:0];
        d_nxt.quo = {d_nxt.quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r  <= d_nxt;
      sd_r <= sd_in;
    end
  end

  assign d_out  = d_r;
  assign sd_out = sd_r;

endmodule

FILE: hdl/wavelet_coeff_quantizer.sv
// an accepted item passes the front register, four divider stages and the output register, then shows on out_valid
// throughput: one item per cycle unless out_stall holds the pipeline; the 16-bit divider is four stages of four bits
// a stalled output holds its item while emptier stages keep accepting
// reset: synchronous active-low rst_n empties the pipeline, quant_step to 1, quant_bias to 0
module wavelet_coeff_quantizer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [15:0] in_coefficient,
  input  logic [15:0]        in_level_magnitude,
  input  logic               in_level_positive,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_value,
  output logic [15:0]        out_magnitude,
  output logic               out_positive,
  output logic               out_clipped,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import wcq_pkg::*;

  `include "wavelet_coeff_quantizer_assert.svh"

  localparam int NSTG = DIV_STAGES + 2;

  logic [15:0]     step_r;
  logic [15:0]     bias_r;
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] rdy;

  front_t f;
  div_t   dv [DIV_STAGES+1];
  side_t  sd [DIV_STAGES+1];
  side_t  sd_rec;

  logic [32:0] r_sum;

  logic signed [15:0] val_r, val_nxt;
  logic [15:0]        mag_r, mag_nxt;
  logic               pos_r, pos_nxt;
  logic               clip_r, clip_nxt;
  logic               mode_r;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 16'd1;
      bias_r <= 16'd0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_STEP: step_r <= pwdata[15:0];
        REG_BIAS: bias_r <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STEP: prdata = {16'd0, step_r};
      REG_BIAS: prdata = {16'd0, bias_r};
      default:  prdata = '0;
    endcase
  end

  // pipeline flow control
  always_comb begin
    rdy[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    v_nxt = v_r;
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NSTG-1];

  wcq_front u_front (
    .clk             (clk),
    .en              (rdy[0]),
    .mode            (in_mode),
    .coefficient     (in_coefficient),
    .level_magnitude (in_level_magnitude),
    .level_positive  (in_level_positive),
    .quant_step      (step_r),
    .quant_bias      (bias_r),
    .f_out           (f)
  );

  // reconstruction: level times step plus bias, negated if negative, saturated; a zero level gives zero
  always_comb begin
    r_sum       = {1'b0, f.prod} + {17'd0, bias_r};
    sd_rec.mode = f.mode;
    sd_rec.neg  = f.neg;
    sd_rec.lmag = f.lmag;
    sd_rec.lpos = f.lpos;
    if (f.lpos) begin
      sd_rec.clip  = (r_sum > 33'd32767);
      sd_rec.recon = sd_rec.clip ? 16'h7fff : r_sum[15:0];
    end else begin
      sd_rec.clip  = (r_sum > 33'd32768);
      sd_rec.recon = sd_rec.clip ? 16'h8000 : 16'(17'h10000 - r_sum[16:0]);
    end
    if (f.lmag == 16'd0) begin
      sd_rec.clip  = 1'b0;
      sd_rec.recon = 16'd0;
    end
  end

  assign sd[0] = sd_rec;
  assign dv[0] = f.div;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    wcq_div_stage u_div (
      .clk    (clk),
      .en     (rdy[k+1]),
      .d_in   (dv[k]),
      .sd_in  (sd[k]),
      .d_out  (dv[k+1]),
      .sd_out (sd[k+1])
    );
  end

  // result assembly
  always_comb begin
    if (sd[DIV_STAGES].mode == MODE_QUANT) begin
      mag_nxt  = dv[DIV_STAGES].quo;
      val_nxt  = sd[DIV_STAGES].neg ? 16'(17'h10000 - {1'b0, dv[DIV_STAGES].quo})
                                    : dv[DIV_STAGES].quo;
      pos_nxt  = !sd[DIV_STAGES].neg && (dv[DIV_STAGES].quo != 16'd0);
      clip_nxt = 1'b0;
    end else begin
      mag_nxt  = sd[DIV_STAGES].lmag;
      val_nxt  = sd[DIV_STAGES].recon;
      pos_nxt  = sd[DIV_STAGES].lpos && (sd[DIV_STAGES].lmag != 16'd0);
      clip_nxt = sd[DIV_STAGES].clip;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTG-1]) begin
      val_r  <= val_nxt;
      mag_r  <= mag_nxt;
      pos_r  <= pos_nxt;
      clip_r <= clip_nxt;
      mode_r <= sd[DIV_STAGES].mode;
    end
  end

  assign out_value     = val_r;
  assign out_magnitude = mag_r;
  assign out_positive  = pos_r;
  assign out_clipped   = clip_r;

  `WCQ_ASSERT_IMPL(a_quant_no_clip, clk, rst_n, out_valid && (mode_r == MODE_QUANT), !out_clipped, "clipped set on a quantized item")
  `WCQ_ASSERT_IMPL(a_zero_level, clk, rst_n, out_valid && (out_magnitude == 16'd0), !out_positive && (out_value == 16'sd0) && !out_clipped, "zero magnitude with nonzero result")
  `WCQ_ASSERT_IMPL(a_full_stall, clk, rst_n, (&v_r) && out_stall, in_stall, "input taken while pipeline is full and stalled")
  `WCQ_ASSERT_NEXT(a_hold_stalled, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_value) && $stable(out_magnitude), "stalled result lost or changed")

endmodule
